FILE: design/env_sensor_compensation_core_macros.svh
// assertion macros shared by the checker files
`ifndef ENV_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ESCC_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ESCC_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/escc_pkg.sv
package escc_pkg;

	// register indexes on the config port (byte address / 8)
	localparam logic [2:0] RegTempCal   = 3'd0;
	localparam logic [2:0] RegPressCalA = 3'd1;
	localparam logic [2:0] RegPressCalB = 3'd2;
	localparam logic [2:0] RegPressCalC = 3'd3;
	localparam logic [2:0] RegHumCalA   = 3'd4;
	localparam logic [2:0] RegHumCalB   = 3'd5;

	// one quotient bit per divider stage
	localparam int DivSteps = 64;

	// result fields riding alongside the pressure divide
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] tf;
		logic        invalid;
		logic [16:0] hum;
	} side_t;

endpackage

FILE: design/escc_sdiv.sv
module escc_sdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [63:0]        dividend,
	input  logic [63:0]        divisor,
	input  logic               in_neg,
	input  escc_pkg::side_t    in_side,
	output logic               out_valid,
	output logic [63:0]        quot,
	output logic               out_neg,
	output escc_pkg::side_t    out_side
);

	localparam int Steps = escc_pkg::DivSteps;

	logic            vld_s  [Steps+1];
	logic [63:0]     rem_s  [Steps+1];
	logic [63:0]     dvd_s  [Steps+1];
	logic [63:0]     dsr_s  [Steps+1];
	logic            neg_s  [Steps+1];
	escc_pkg::side_t side_s [Steps+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign dvd_s[0]  = dividend;
	assign dsr_s[0]  = divisor;
	assign neg_s[0]  = in_neg;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [64:0] top;
		logic [64:0] diff;
		logic        ge;

		// restoring step: shift in next dividend bit, try subtract
		always_comb begin
			top  = {rem_s[k], dvd_s[k][63]};
			diff = top - {1'b0, dsr_s[k]};
			ge   = top >= {1'b0, dsr_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[63:0] : top[63:0];
				dvd_s[k+1]  <= {dvd_s[k][62:0], ge};
				dsr_s[k+1]  <= dsr_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign quot      = dvd_s[Steps];
	assign out_neg   = neg_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

FILE: design/env_sensor_compensation_core.sv
// environmental sensor compensation core
//
// input stream (s_t*): one word per reading triple, raw temperature,
// raw pressure and raw humidity packed in s_tdata. output stream (m_t*):
// one result word per input word, in order, with the pressure-invalid
// flag on m_tuser.
// calibration words sit in six registers on the apb-style port, each at
// byte address 8*i; write them only while no word is in flight.
//
// pipeline: an accepted word passes 10 stages of temperature, humidity
// and pressure setup, 64 stages of the restoring divider (one quotient
// bit each), 3 stages of pressure correction and the output register
// before it shows on m_tvalid/m_tdata.
// throughput: one word per cycle while not stalled; every stage is a
// register with a valid bit, so a new word can follow in the very next cycle.
// stall: when m_tready is low with a word waiting, the whole pipe
// freezes and s_tready drops in the same cycle; nothing is dropped or
// repeated. s_tready is high whenever the output register is empty.
// reset: arst_n clears all valid bits and the calibration registers;
// the pipe is then empty and ready.
module env_sensor_compensation_core (
	input  logic         clk,
	input  logic         arst_n,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // temperature_centi[31:0], fine_temperature[63:32],
	                                // pressure_q24_8[95:64], humidity_q22_10[112:96], zero pad
	output logic         m_tuser    // pressure_invalid
);

	// ---------------- calibration registers ----------------
	logic [47:0] temp_cal_q, press_cal_a_q, press_cal_b_q, press_cal_c_q;
	logic [31:0] hum_cal_a_q;
	logic [39:0] hum_cal_b_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
			hum_cal_a_q   <= '0;
			hum_cal_b_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[5:3])
				escc_pkg::RegTempCal:   temp_cal_q    <= pwdata[47:0];
				escc_pkg::RegPressCalA: press_cal_a_q <= pwdata[47:0];
				escc_pkg::RegPressCalB: press_cal_b_q <= pwdata[47:0];
				escc_pkg::RegPressCalC: press_cal_c_q <= pwdata[47:0];
				escc_pkg::RegHumCalA:   hum_cal_a_q   <= pwdata[31:0];
				escc_pkg::RegHumCalB:   hum_cal_b_q   <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			escc_pkg::RegTempCal:   prdata = {16'b0, temp_cal_q};
			escc_pkg::RegPressCalA: prdata = {16'b0, press_cal_a_q};
			escc_pkg::RegPressCalB: prdata = {16'b0, press_cal_b_q};
			escc_pkg::RegPressCalC: prdata = {16'b0, press_cal_c_q};
			escc_pkg::RegHumCalA:   prdata = {32'b0, hum_cal_a_q};
			escc_pkg::RegHumCalB:   prdata = {24'b0, hum_cal_b_q};
			default:                prdata = '0;
		endcase
	end

	// calibration fields
	logic [15:0] t1;
	logic [31:0] t2x, t3x;
	logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1x, h2x, h3x, h4x, h5x, h6x;

	always_comb begin
		t1  = temp_cal_q[15:0];
		t2x = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
		t3x = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
		p1  = press_cal_a_q[15:0];
		p2  = press_cal_a_q[31:16];
		p3  = press_cal_a_q[47:32];
		p4  = press_cal_b_q[15:0];
		p5  = press_cal_b_q[31:16];
		p6  = press_cal_b_q[47:32];
		p7  = press_cal_c_q[15:0];
		p8  = press_cal_c_q[31:16];
		p9  = press_cal_c_q[47:32];
		h1x = {24'b0, hum_cal_a_q[7:0]};
		h2x = {{16{hum_cal_a_q[23]}}, hum_cal_a_q[23:8]};
		h3x = {24'b0, hum_cal_a_q[31:24]};
		h4x = {{16{hum_cal_b_q[15]}}, hum_cal_b_q[15:0]};
		h5x = {{16{hum_cal_b_q[31]}}, hum_cal_b_q[31:16]};
		h6x = {{24{hum_cal_b_q[39]}}, hum_cal_b_q[39:32]};
	end

	// ---------------- pipeline control ----------------
	// the whole pipe advances together unless a finished word waits
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s75, v_s76, v_s77;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			{v_s75, v_s76, v_s77} <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s75       <= div_vld;
			v_s76       <= v_s75;
			v_s77       <= v_s76;
			out_valid_q <= v_s77;
		end
	end

	// ---------------- temperature, stages 1..3 ----------------
	logic [19:0] adc_t, adc_p;
	logic [15:0] adc_h;
	logic [31:0] ta, td;

	assign adc_t = s_tdata[19:0];
	assign adc_p = s_tdata[39:20];
	assign adc_h = s_tdata[55:40];

	always_comb begin
		ta = {15'b0, adc_t[19:3]} - {15'b0, t1, 1'b0};
		td = {16'b0, adc_t[19:4]} - {16'b0, t1};
	end

	logic [31:0] tma_s1, tdd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic [15:0] adch_s1, adch_s2, adch_s3;
	logic [31:0] ta_s2, tm_s2, tf_s3;
	logic [31:0] tdd_sh;

	assign tdd_sh = $signed(tdd_s1) >>> 12;

	always_ff @(posedge clk) begin
		if (adv) begin
			tma_s1  <= ta * t2x;
			tdd_s1  <= td * td;
			adcp_s1 <= adc_p;
			adch_s1 <= adc_h;
			ta_s2   <= $signed(tma_s1) >>> 11;
			tm_s2   <= tdd_sh * t3x;
			adcp_s2 <= adcp_s1;
			adch_s2 <= adch_s1;
			tf_s3   <= $signed(ta_s2) + ($signed(tm_s2) >>> 14);
			adcp_s3 <= adcp_s2;
			adch_s3 <= adch_s2;
		end
	end

	// ---------------- stage 4: split into pressure and humidity ----------------
	logic [31:0] temp_c, hx4;
	logic [31:0] temp5;

	always_comb begin
		temp5  = tf_s3 * 32'd5 + 32'd128;
		temp_c = $signed(temp5) >>> 8;
		hx4    = tf_s3 - 32'd76800;
	end

	escc_pkg::side_t side_s4, side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	logic [63:0] v1_s4;
	logic [31:0] h5x_s4, xh6_s4, xh3_s4, hpre_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= '{temp: temp_c, tf: tf_s3, invalid: 1'b0, hum: 17'd0};
			v1_s4   <= {{32{tf_s3[31]}}, tf_s3} - 64'd128000;
			adcp_s4 <= adcp_s3;
			h5x_s4  <= h5x * hx4;
			xh6_s4  <= hx4 * h6x;
			xh3_s4  <= hx4 * h3x;
			hpre_s4 <= {2'b0, adch_s3, 14'b0} - {h4x[11:0], 20'b0};
		end
	end

	// ---------------- pressure setup, stages 5..9 ----------------
	logic signed [67:0] sq_full;
	logic signed [49:0] v1p5_full, v1p2_full;

	always_comb begin
		sq_full   = $signed(v1_s4[33:0]) * $signed(v1_s4[33:0]);
		v1p5_full = $signed(v1_s4[33:0]) * $signed(p5);
		v1p2_full = $signed(v1_s4[33:0]) * $signed(p2);
	end

	logic [63:0] sq_s5, v1p5_s5, v1p2_s5;
	logic [63:0] sqp6_s6, sqp3_s6, v1p5_s6, v1p2_s6;
	logic [63:0] v2_s7, t_s7, v2_s8, tp1_s8;
	logic [63:0] num_s9, den_s9;
	logic [63:0] v1b, sqp3_sh, pp, pn;

	always_comb begin
		sqp3_sh = $signed(sqp3_s6) >>> 8;
		v1b     = sqp3_sh + {v1p2_s6[51:0], 12'b0};
		pp      = 64'd1048576 - {44'b0, adcp_s8};
		pn      = {pp[32:0], 31'b0} - v2_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5   <= sq_full[63:0];
			v1p5_s5 <= {{14{v1p5_full[49]}}, v1p5_full};
			v1p2_s5 <= {{14{v1p2_full[49]}}, v1p2_full};
			adcp_s5 <= adcp_s4;

			sqp6_s6 <= $signed(sq_s5) * $signed(p6);
			sqp3_s6 <= $signed(sq_s5) * $signed(p3);
			v1p5_s6 <= v1p5_s5;
			v1p2_s6 <= v1p2_s5;
			adcp_s6 <= adcp_s5;

			v2_s7   <= sqp6_s6 + {v1p5_s6[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
			t_s7    <= 64'h0000_8000_0000_0000 + v1b;
			adcp_s7 <= adcp_s6;

			tp1_s8  <= t_s7 * {48'b0, p1};
			v2_s8   <= v2_s7;
			adcp_s8 <= adcp_s7;

			num_s9  <= pn * 64'd3125;
			den_s9  <= $signed(tp1_s8) >>> 33;
		end
	end

	// ---------------- humidity, stages 5..10 ----------------
	logic [31:0] hsum5, hu5, hw5, hb6, hc7, hd8, hdd8, hx10;
	logic [31:0] ha_s5, uw_s5, ha_s6, bh2_s6, hx_s7, hx_s8, hdd_s8, hx_s9, he_s9;
	logic [16:0] hum_d;

	always_comb begin
		hsum5 = hpre_s4 - h5x_s4 + 32'd16384;
		hu5   = $signed(xh6_s4) >>> 10;
		hw5   = ($signed(xh3_s4) >>> 11) + 32'sd32768;
		hb6   = ($signed(uw_s5) >>> 10) + 32'sd2097152;
		hc7   = $signed(bh2_s6 + 32'd8192) >>> 14;
		hd8   = $signed(hx_s7) >>> 15;
		hdd8  = $signed(hdd_s8) >>> 7;
		hx10  = $signed(hx_s9) - ($signed(he_s9) >>> 4);
		// clamp to 0..100 %RH
		if (hx10[31]) begin
			hum_d = '0;
		end else if (hx10 > 32'd419430400) begin
			hum_d = 17'd102400;
		end else begin
			hum_d = hx10[28:12];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ha_s5  <= $signed(hsum5) >>> 15;
			uw_s5  <= hu5 * hw5;
			ha_s6  <= ha_s5;
			bh2_s6 <= hb6 * h2x;
			hx_s7  <= ha_s6 * hc7;
			hx_s8  <= hx_s7;
			hdd_s8 <= hd8 * hd8;
			hx_s9  <= hx_s8;
			he_s9  <= hdd8 * h1x;
		end
	end

	// side fields: invalid is known at stage 9, humidity at stage 10
	logic [63:0] ma_s10, mb_s10;
	logic        neg_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5  <= side_s4;
			side_s6  <= side_s5;
			side_s7  <= side_s6;
			side_s8  <= side_s7;
			side_s9  <= side_s8;
			side_s10 <= '{temp: side_s9.temp, tf: side_s9.tf,
				invalid: (den_s9 == 64'd0), hum: hum_d};
			ma_s10   <= num_s9[63] ? (64'd0 - num_s9) : num_s9;
			mb_s10   <= den_s9[63] ? (64'd0 - den_s9) : den_s9;
			neg_s10  <= num_s9[63] ^ den_s9[63];
		end
	end

	// ---------------- divider, stages 11..74 ----------------
	logic [63:0]     div_q;
	logic            div_neg;
	escc_pkg::side_t div_side;

	escc_sdiv u_sdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s10),
		.dividend  (ma_s10),
		.divisor   (mb_s10),
		.in_neg    (neg_s10),
		.in_side   (side_s10),
		.out_valid (div_vld),
		.quot      (div_q),
		.out_neg   (div_neg),
		.out_side  (div_side)
	);

	// ---------------- pressure correction, stages 75..77 ----------------
	escc_pkg::side_t side_s75, side_s76, side_s77;
	logic [63:0] q_s75, q_s76, q_s77;
	logic [63:0] a9_s76, v2p_s76, v2_s77, ll_s77;
	logic [31:0] lh_s77, hl_s77;
	logic [63:0] pd76, pd77;

	assign pd76 = $signed(q_s75) >>> 13;
	assign pd77 = $signed(q_s76) >>> 13;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s75    <= div_neg ? (64'd0 - div_q) : div_q;
			side_s75 <= div_side;

			a9_s76   <= $signed(pd76) * $signed(p9);
			v2p_s76  <= $signed(q_s75) * $signed(p8);
			q_s76    <= q_s75;
			side_s76 <= side_s75;

			// 64x64 low product from 32-bit partials
			ll_s77   <= {32'b0, a9_s76[31:0]} * {32'b0, pd77[31:0]};
			lh_s77   <= a9_s76[31:0] * pd77[63:32];
			hl_s77   <= a9_s76[63:32] * pd77[31:0];
			v2_s77   <= $signed(v2p_s76) >>> 19;
			q_s77    <= q_s76;
			side_s77 <= side_s76;
		end
	end

	logic [63:0] prod78, v1o, psum, pres;
	logic [31:0] cross78;

	always_comb begin
		cross78 = lh_s77 + hl_s77;
		prod78  = ll_s77 + {cross78, 32'b0};
		v1o     = $signed(prod78) >>> 25;
		psum    = q_s77 + v1o + v2_s77;
		pres    = ($signed(psum) >>> 8) + $signed({{44{p7[15]}}, p7, 4'b0});
	end

	// ---------------- output register ----------------
	logic [31:0] out_temp_q, out_tf_q, out_pres_q;
	logic [16:0] out_hum_q;
	logic        out_inv_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_temp_q <= side_s77.temp;
			out_tf_q   <= side_s77.tf;
			out_pres_q <= side_s77.invalid ? 32'd0 : pres[31:0];
			out_inv_q  <= side_s77.invalid;
			out_hum_q  <= side_s77.hum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_hum_q, out_pres_q, out_tf_q, out_temp_q};
	assign m_tuser  = out_inv_q;

endmodule

FILE: design/escc_checker.sv
`include "env_sensor_compensation_core_macros.svh"

module escc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic         m_tuser
);

	// a waiting word holds until taken
	`ESCC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// empty output register never blocks the input
	`ESCC_ASSERT_IMP(a_ready_free, !m_tvalid, s_tready, "input blocked with empty output")

	// zero divisor forces zero pressure
	`ESCC_ASSERT_IMP(a_inv_zero, m_tvalid && m_tuser, m_tdata[95:64] == 32'd0, "invalid pressure not zero")

	// humidity clamp and zero padding
	`ESCC_ASSERT_IMP(a_hum_range, m_tvalid, m_tdata[112:96] <= 17'd102400 && m_tdata[119:113] == 7'd0, "humidity out of range")

endmodule

bind env_sensor_compensation_core escc_checker u_escc_checker (.*);

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkHalf = 2;
	localparam int PipeLatency = 77;
	localparam int CycleLimit = 1000000;
	localparam int RandItems = 400;

	// one expected output word, fields as they leave the core
	typedef struct packed {
		logic [31:0] temp_centi;
		logic [31:0] fine_temp;
		logic [31:0] pres_q24_8;
		logic        pres_invalid;
		logic [16:0] hum_q22_10;
	} comp_word_t;

	logic          clk;
	logic          arst_n;
	logic          psel, penable, pwrite;
	logic [5:0]    paddr;
	logic [63:0]   pwdata;
	logic [63:0]   prdata;
	logic          pready;
	logic          s_tvalid;
	logic          s_tready;
	logic [55:0]   s_tdata;   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
	logic          m_tvalid;
	logic          m_tready;
	logic [119:0]  m_tdata;   // temperature_centi, fine_temperature, pressure_q24_8,
	                          // humidity_q22_10, zero pad
	logic          m_tuser;   // pressure_invalid

	// shadow copy of the calibration registers
	logic [63:0]   cal [6];
	logic [55:0]   raw_words [$];
	comp_word_t    pending_results [$];
	int            src_idle_pct;
	int            snk_stall_pct;
	int            snk_hold;
	int            fail_count;
	int            cycle_count;

	env_sensor_compensation_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #ClkHalf clk = ~clk;
	end

	// integer compensation, wrapping 32-bit and 64-bit arithmetic
	function automatic comp_word_t compensate(logic [55:0] w);
		int adc_t, adc_p, adc_h;
		int t1, t2, t3, h1, h2, h3, h4, h5, h6;
		longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
		int a, b, c, d, tf, x;
		longint v1, v2, p, num;
		comp_word_t r;
		adc_t = int'(w[19:0]);
		adc_p = int'(w[39:20]);
		adc_h = int'(w[55:40]);
		t1 = int'(cal[escc_pkg::RegTempCal][15:0]);
		t2 = shortint'(cal[escc_pkg::RegTempCal][31:16]);
		t3 = shortint'(cal[escc_pkg::RegTempCal][47:32]);
		p1 = longint'(cal[escc_pkg::RegPressCalA][15:0]);
		p2 = shortint'(cal[escc_pkg::RegPressCalA][31:16]);
		p3 = shortint'(cal[escc_pkg::RegPressCalA][47:32]);
		p4 = shortint'(cal[escc_pkg::RegPressCalB][15:0]);
		p5 = shortint'(cal[escc_pkg::RegPressCalB][31:16]);
		p6 = shortint'(cal[escc_pkg::RegPressCalB][47:32]);
		p7 = shortint'(cal[escc_pkg::RegPressCalC][15:0]);
		p8 = shortint'(cal[escc_pkg::RegPressCalC][31:16]);
		p9 = shortint'(cal[escc_pkg::RegPressCalC][47:32]);
		h1 = int'(cal[escc_pkg::RegHumCalA][7:0]);
		h2 = shortint'(cal[escc_pkg::RegHumCalA][23:8]);
		h3 = int'(cal[escc_pkg::RegHumCalA][31:24]);
		h4 = shortint'(cal[escc_pkg::RegHumCalB][15:0]);
		h5 = shortint'(cal[escc_pkg::RegHumCalB][31:16]);
		h6 = byte'(cal[escc_pkg::RegHumCalB][39:32]);

		// temperature
		a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		tf = a + b;
		r.temp_centi = (tf * 5 + 128) >>> 8;
		r.fine_temp = tf;

		// pressure
		v1 = longint'(tf) - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.pres_q24_8 = '0;
			r.pres_invalid = 1'b1;
		end else begin
			p = 64'sd1048576 - longint'(adc_p);
			num = ((p <<< 31) - v2) * 64'sd3125;
			// most negative over minus one wraps to itself
			if (v1 == -64'sd1)
				p = -num;
			else
				p = num / v1;
			v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			v2 = (p8 * p) >>> 19;
			p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
			r.pres_q24_8 = p[31:0];
			r.pres_invalid = 1'b0;
		end

		// humidity
		x = tf - 76800;
		a = ((adc_h <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
		b = ((((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768)) >>> 10) + 2097152;
		c = (b * h2 + 8192) >>> 14;
		x = a * c;
		d = x >>> 15;
		x = x - ((((d * d) >>> 7) * h1) >>> 4);
		if (x < 0)
			x = 0;
		if (x > 419430400)
			x = 419430400;
		r.hum_q22_10 = 17'(x >>> 12);
		return r;
	endfunction

	// stream driver: pops raw words, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (raw_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= raw_words.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink: random stalls plus an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (snk_hold > 0) begin
			snk_hold <= snk_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// monitor: predict on accept, check on delivery
	always @(posedge clk) begin
		comp_word_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(compensate(s_tdata));
			if (m_tvalid && m_tready) begin
				got.temp_centi = m_tdata[31:0];
				got.fine_temp = m_tdata[63:32];
				got.pres_q24_8 = m_tdata[95:64];
				got.hum_q22_10 = m_tdata[112:96];
				got.pres_invalid = m_tuser;
				if (pending_results.size() == 0) begin
					$error("output word with nothing pending");
					fail_count = fail_count + 1;
				end else begin
					want = pending_results.pop_front();
					if (got.temp_centi !== want.temp_centi) begin
						$error("temperature_centi exp %0d got %0d",
							$signed(want.temp_centi), $signed(got.temp_centi));
						fail_count = fail_count + 1;
					end
					if (got.fine_temp !== want.fine_temp) begin
						$error("fine_temperature exp %0d got %0d",
							$signed(want.fine_temp), $signed(got.fine_temp));
						fail_count = fail_count + 1;
					end
					if (got.pres_q24_8 !== want.pres_q24_8) begin
						$error("pressure_q24_8 exp %h got %h", want.pres_q24_8, got.pres_q24_8);
						fail_count = fail_count + 1;
					end
					if (got.pres_invalid !== want.pres_invalid) begin
						$error("pressure_invalid exp %b got %b",
							want.pres_invalid, got.pres_invalid);
						fail_count = fail_count + 1;
					end
					if (got.hum_q22_10 !== want.hum_q22_10) begin
						$error("humidity_q22_10 exp %0d got %0d", want.hum_q22_10, got.hum_q22_10);
						fail_count = fail_count + 1;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// register write, setup phase then access phase; upper bits beyond the register width are dropped
	task automatic write_cal(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			escc_pkg::RegHumCalA: cal[idx] = value & 64'hFFFF_FFFF;
			escc_pkg::RegHumCalB: cal[idx] = value & 64'hFF_FFFF_FFFF;
			default:              cal[idx] = value & 64'hFFFF_FFFF_FFFF;
		endcase
	endtask

	task automatic load_cal(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
		logic [63:0] pc, logic [63:0] ha, logic [63:0] hb);
		write_cal(escc_pkg::RegTempCal, tc);
		write_cal(escc_pkg::RegPressCalA, pa);
		write_cal(escc_pkg::RegPressCalB, pb);
		write_cal(escc_pkg::RegPressCalC, pc);
		write_cal(escc_pkg::RegHumCalA, ha);
		write_cal(escc_pkg::RegHumCalB, hb);
	endtask

	// wait for the pipe to run dry, then let it settle
	task automatic drain();
		while (raw_words.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (PipeLatency + 8) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// readings near a typical operating point, or fully random, or at the extremes
	function automatic logic [55:0] rand_raw();
		logic [19:0] t, p;
		logic [15:0] h;
		case ($urandom_range(9))
			0: begin
				t = $urandom_range(1) ? 20'hFFFFF : 20'h0;
				p = $urandom_range(1) ? 20'hFFFFF : 20'h0;
				h = $urandom_range(1) ? 16'hFFFF : 16'h0;
			end
			1, 2, 3, 4: begin
				t = 20'($urandom_range(1048575));
				p = 20'($urandom_range(1048575));
				h = 16'($urandom_range(65535));
			end
			default: begin
				t = 20'($urandom_range(560000, 480000));
				p = 20'($urandom_range(460000, 250000));
				h = 16'($urandom_range(40000, 20000));
			end
		endcase
		return {h, p, t};
	endfunction

	// typical part calibration, optionally lightly perturbed
	task automatic load_typical(bit perturb);
		logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
		logic [7:0]  h1, h3, h6;
		t1 = 16'd27504; t2 = 16'd26435; t3 = -16'sd1000;
		p1 = 16'd36477; p2 = -16'sd10685; p3 = 16'd3024; p4 = 16'd2855;
		p5 = 16'd140; p6 = -16'sd7; p7 = 16'd15500; p8 = -16'sd14600; p9 = 16'd6000;
		h1 = 8'd75; h2 = 16'd362; h3 = 8'd0; h4 = 16'd313; h5 = 16'd50; h6 = 8'd30;
		if (perturb) begin
			t1 += 16'($urandom_range(2000) - 1000);
			t2 += 16'($urandom_range(2000) - 1000);
			p1 += 16'($urandom_range(4000) - 2000);
			p8 += 16'($urandom_range(400) - 200);
			h2 += 16'($urandom_range(40) - 20);
			h3 = 8'($urandom_range(255));
			h6 = 8'($urandom_range(60));
		end
		load_cal({16'hA5A5, t3, t2, t1}, {16'h5A5A, p3, p2, p1}, {16'h0, p6, p5, p4},
			{16'h0, p9, p8, p7}, {32'hFFFF_0000, h3, h2, h1},
			{24'hFFFF_FF, h6, h5, h4});
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		snk_hold = 0;
		fail_count = 0;
		cycle_count = 0;
		foreach (cal[i])
			cal[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zeroed calibration: zero divisor on every word
		raw_words.push_back({16'h0, 20'h0, 20'h0});
		raw_words.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		raw_words.push_back({16'd30000, 20'd415148, 20'd519888});
		drain();

		// typical calibration with edge and typical readings
		load_typical(1'b0);
		raw_words.push_back({16'd30000, 20'd415148, 20'd519888});
		raw_words.push_back({16'h0, 20'h0, 20'h0});
		raw_words.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		raw_words.push_back({16'h0, 20'hFFFFF, 20'h0});
		raw_words.push_back({16'hFFFF, 20'h0, 20'hFFFFF});
		raw_words.push_back({16'd65000, 20'd300000, 20'd540000});
		raw_words.push_back({16'd1000, 20'd450000, 20'd480000});
		drain();

		// extreme calibration: all ones, then most negative, then most positive signed words
		load_cal('1, '1, '1, '1, '1, '1);
		raw_words.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		raw_words.push_back({16'h0, 20'h0, 20'h0});
		raw_words.push_back({16'd30000, 20'd415148, 20'd519888});
		drain();
		load_cal(64'h8000_8000_FFFF, 64'h8000_8000_FFFF, 64'h8000_8000_8000,
			64'h8000_8000_8000, 64'h80_8000_FF, 64'h80_8000_8000);
		raw_words.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		raw_words.push_back({16'h0, 20'h0, 20'h0});
		raw_words.push_back({16'd30000, 20'd415148, 20'd519888});
		drain();
		load_cal(64'h7FFF_7FFF_0001, 64'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF,
			64'h7FFF_7FFF_7FFF, 64'h7F_7FFF_01, 64'h7F_7FFF_7FFF);
		raw_words.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		raw_words.push_back({16'h0, 20'h0, 20'h0});
		drain();

		// random phases over several idling profiles
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
				3: begin src_idle_pct = 25; snk_stall_pct = 25; end
				default: begin src_idle_pct = 0; snk_stall_pct = 0; end
			endcase
			if (ph == 2)
				load_cal(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
			else
				load_typical(ph != 0);
			for (int n = 0; n < RandItems; n++) begin
				raw_words.push_back(rand_raw());
				// mid-phase: sender pauses until every result is back
				if (ph == 3 && n == RandItems / 2)
					drain();
			end
			// long hold-off so the pipe fills and s_tready drops
			if (ph == 4)
				snk_hold = 400;
			drain();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
